### rtl/core/rco_pkg.sv
// rco_pkg: widths, stage payload types and shape codes of the rectangle/circle
// overlap pipeline. No dependencies; used by every file under rtl/core.
`default_nettype none

package rco_pkg;

  // Coordinate width; sizes are one bit narrower and unsigned.
  localparam int COORD_BITS = 16;
  localparam int SIZE_BITS  = COORD_BITS - 1;
  localparam int EDGE_BITS  = COORD_BITS + 1;   // corner plus size
  localparam int MAG_BITS   = COORD_BITS;       // gap magnitude or radius term
  localparam int SQ_BITS    = 2 * MAG_BITS;
  localparam int SUM_BITS   = SQ_BITS + 1;

  // Stream packing.
  localparam int SHAPE_BITS     = 2 * COORD_BITS + 2 * SIZE_BITS;
  localparam int IN_FIELD_BITS  = 2 * SHAPE_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int IN_TUSER_BITS  = 2;
  localparam int OUT_TDATA_BITS = 8;

  // One shape as packed on tdata, x in the lowest bits.
  typedef struct packed {
    logic        [SIZE_BITS-1:0]  h;
    logic        [SIZE_BITS-1:0]  w;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] x;
  } geom_t;

  typedef enum logic [1:0] {
    MODE_RR = 2'd0,   // rectangle with rectangle
    MODE_CC = 2'd1,   // circle with circle
    MODE_RC = 2'd2    // rectangle with circle, either order
  } mode_t;

  // After stage 1: circle centre and the box it is measured against.
  typedef struct packed {
    mode_t                        mode;
    logic                         rr_hit;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [EDGE_BITS-1:0]  lox;
    logic signed [EDGE_BITS-1:0]  hix;
    logic signed [EDGE_BITS-1:0]  loy;
    logic signed [EDGE_BITS-1:0]  hiy;
    logic        [MAG_BITS-1:0]   rt;
  } s1_t;

  // After stage 2: gap magnitudes on each axis.
  typedef struct packed {
    mode_t               mode;
    logic                rr_hit;
    logic [MAG_BITS-1:0] ex;
    logic [MAG_BITS-1:0] ey;
    logic [MAG_BITS-1:0] rt;
  } s2_t;

  // After stage 3: squares.
  typedef struct packed {
    mode_t              mode;
    logic               rr_hit;
    logic [SQ_BITS-1:0] sqx;
    logic [SQ_BITS-1:0] sqy;
    logic [SQ_BITS-1:0] sqr;
  } s3_t;

endpackage

`default_nettype wire

### rtl/core/rco_front.sv
// rco_front: stage 1, unpacks both shapes, runs the box test and picks the
// centre/box pair for the distance path. Depends on rco_pkg.
`default_nettype none

module rco_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire logic                               in_valid,
  input  wire logic [rco_pkg::IN_FIELD_BITS-1:0]  fields,
  input  wire logic [rco_pkg::IN_TUSER_BITS-1:0]  kinds,
  output rco_pkg::s1_t                            s1,
  output logic                                    s1_valid
);

  rco_pkg::geom_t a;
  rco_pkg::geom_t b;
  logic signed [rco_pkg::EDGE_BITS-1:0] a_xlo, a_xhi, a_ylo, a_yhi;
  logic signed [rco_pkg::EDGE_BITS-1:0] b_xlo, b_xhi, b_ylo, b_yhi;
  logic         rr_sep;
  rco_pkg::s1_t s1_next;

  assign a = rco_pkg::geom_t'(fields[rco_pkg::SHAPE_BITS-1:0]);
  assign b = rco_pkg::geom_t'(fields[rco_pkg::IN_FIELD_BITS-1:rco_pkg::SHAPE_BITS]);

  // Span edges, one bit wider so corner + size cannot wrap.
  assign a_xlo = {a.x[rco_pkg::COORD_BITS-1], a.x};
  assign a_ylo = {a.y[rco_pkg::COORD_BITS-1], a.y};
  assign b_xlo = {b.x[rco_pkg::COORD_BITS-1], b.x};
  assign b_ylo = {b.y[rco_pkg::COORD_BITS-1], b.y};
  assign a_xhi = a_xlo + $signed({2'b00, a.w});
  assign a_yhi = a_ylo + $signed({2'b00, a.h});
  assign b_xhi = b_xlo + $signed({2'b00, b.w});
  assign b_yhi = b_ylo + $signed({2'b00, b.h});

  // Touching edges are not a separation.
  assign rr_sep = (a_xhi < b_xlo) || (a_xlo > b_xhi) ||
                  (a_yhi < b_ylo) || (a_ylo > b_yhi);

  always_comb begin
    s1_next        = '0;
    s1_next.rr_hit = !rr_sep;
    unique case ({kinds[1], kinds[0]})
      2'b00: begin
        s1_next.mode = rco_pkg::MODE_RR;
      end
      2'b11: begin
        // Circle pair: distance from centre a to the point at centre b.
        s1_next.mode = rco_pkg::MODE_CC;
        s1_next.cx   = a.x;
        s1_next.cy   = a.y;
        s1_next.lox  = b_xlo;
        s1_next.hix  = b_xlo;
        s1_next.loy  = b_ylo;
        s1_next.hiy  = b_ylo;
        s1_next.rt   = {1'b0, a.w} + {1'b0, b.w};
      end
      2'b10: begin
        // a rectangle, b circle
        s1_next.mode = rco_pkg::MODE_RC;
        s1_next.cx   = b.x;
        s1_next.cy   = b.y;
        s1_next.lox  = a_xlo;
        s1_next.hix  = a_xhi;
        s1_next.loy  = a_ylo;
        s1_next.hiy  = a_yhi;
        s1_next.rt   = {1'b0, b.w};
      end
      2'b01: begin
        // a circle, b rectangle
        s1_next.mode = rco_pkg::MODE_RC;
        s1_next.cx   = a.x;
        s1_next.cy   = a.y;
        s1_next.lox  = b_xlo;
        s1_next.hix  = b_xhi;
        s1_next.loy  = b_ylo;
        s1_next.hiy  = b_yhi;
        s1_next.rt   = {1'b0, a.w};
      end
      default: begin
        s1_next.mode = rco_pkg::MODE_RR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rco_dist.sv
// rco_dist: stage 2, gap from the centre to the clamped box on each axis.
// Depends on rco_pkg.
`default_nettype none

module rco_dist (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire rco_pkg::s1_t s1,
  input  wire logic         s1_valid,
  output rco_pkg::s2_t      s2,
  output logic              s2_valid
);

  logic signed [rco_pkg::EDGE_BITS-1:0] cx_e, cy_e;
  logic signed [rco_pkg::EDGE_BITS-1:0] gx, gy;
  rco_pkg::s2_t s2_next;

  assign cx_e = {s1.cx[rco_pkg::COORD_BITS-1], s1.cx};
  assign cy_e = {s1.cy[rco_pkg::COORD_BITS-1], s1.cy};

  // Gap is zero inside the span, else the distance to the nearer edge.
  always_comb begin
    priority if (cx_e > s1.hix) begin
      gx = cx_e - s1.hix;
    end else if (cx_e < s1.lox) begin
      gx = s1.lox - cx_e;
    end else begin
      gx = '0;
    end
    priority if (cy_e > s1.hiy) begin
      gy = cy_e - s1.hiy;
    end else if (cy_e < s1.loy) begin
      gy = s1.loy - cy_e;
    end else begin
      gy = '0;
    end
    s2_next.mode   = s1.mode;
    s2_next.rr_hit = s1.rr_hit;
    s2_next.ex     = gx[rco_pkg::MAG_BITS-1:0];
    s2_next.ey     = gy[rco_pkg::MAG_BITS-1:0];
    s2_next.rt     = s1.rt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s2_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rco_square.sv
// rco_square: stage 3, three parallel squarers for both gaps and the radius term.
// Depends on rco_pkg.
`default_nettype none

module rco_square (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire rco_pkg::s2_t s2,
  input  wire logic         s2_valid,
  output rco_pkg::s3_t      s3,
  output logic              s3_valid
);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3.mode   <= s2.mode;
      s3.rr_hit <= s2.rr_hit;
      s3.sqx    <= rco_pkg::SQ_BITS'(s2.ex) * rco_pkg::SQ_BITS'(s2.ex);
      s3.sqy    <= rco_pkg::SQ_BITS'(s2.ey) * rco_pkg::SQ_BITS'(s2.ey);
      s3.sqr    <= rco_pkg::SQ_BITS'(s2.rt) * rco_pkg::SQ_BITS'(s2.rt);
    end
  end

endmodule

`default_nettype wire

### rtl/core/rco_judge.sv
// rco_judge: stage 4, sums the squared gaps, compares against the radius term
// and holds the result in the output register. Depends on rco_pkg.
`default_nettype none

module rco_judge (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire rco_pkg::s3_t s3,
  input  wire logic         s3_valid,
  output logic              hit,
  output logic              out_valid
);

  logic [rco_pkg::SUM_BITS-1:0] d2;
  logic [rco_pkg::SUM_BITS-1:0] r2;
  logic                         hit_next;

  assign d2 = {1'b0, s3.sqx} + {1'b0, s3.sqy};
  assign r2 = {1'b0, s3.sqr};

  always_comb begin
    unique case (s3.mode)
      rco_pkg::MODE_RR: hit_next = s3.rr_hit;
      rco_pkg::MODE_CC: hit_next = (d2 <= r2);   // tangent circles touch
      rco_pkg::MODE_RC: hit_next = (d2 < r2);    // strict for box vs circle
      default:          hit_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= hit_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rect_circle_overlap_test.sv
// rect_circle_overlap_test: top level of the rectangle/circle overlap pipeline.
// Depends on rco_pkg, rco_front, rco_dist, rco_square and rco_judge.
//
//  channel | dir | signals                          | one transfer
//  --------+-----+----------------------------------+-----------------------------
//  s_      | in  | s_tvalid s_tready s_tdata s_tuser | one shape pair
//  m_      | out | m_tvalid m_tready m_tdata         | one hit flag
//
// Throughput is one transfer per cycle while no result is stalled on m_tready;
// four register stages (decode/box test, axis gaps, squarers, sum and compare)
// lie between the input transfer and m_tvalid, the last being the output register.
// The four stages share one enable: they advance whenever the output register
// is empty or being taken, so s_tready follows m_tready within the cycle.
// A stall freezes every stage and its valid bit, so nothing is lost or repeated.
// rst is synchronous, active high, and clears the valid bits only.
`default_nettype none

module rect_circle_overlap_test (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // lsb up: a_x, a_y, a_width, a_height, b_x, b_y, b_width, b_height, zero pad
  input  wire logic [rco_pkg::IN_TDATA_BITS-1:0]  s_tdata,
  // lsb up: a_is_circle, b_is_circle
  input  wire logic [rco_pkg::IN_TUSER_BITS-1:0]  s_tuser,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // lsb up: hit, zero pad
  output logic [rco_pkg::OUT_TDATA_BITS-1:0]      m_tdata
);

  logic         en;
  rco_pkg::s1_t s1;
  rco_pkg::s2_t s2;
  rco_pkg::s3_t s3;
  logic         s1_valid, s2_valid, s3_valid;
  logic         hit;

  // Whole pipeline moves unless a finished result is waiting on the sink.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Stage 1: unpack, rectangle test, pick centre and box.
  rco_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .fields   (s_tdata[rco_pkg::IN_FIELD_BITS-1:0]),
    .kinds    (s_tuser),
    .s1       (s1),
    .s1_valid (s1_valid)
  );

  // Stage 2: per-axis gap to the clamped point.
  rco_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .s1       (s1),
    .s1_valid (s1_valid),
    .s2       (s2),
    .s2_valid (s2_valid)
  );

  // Stage 3: squares.
  rco_square u_square (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .s2       (s2),
    .s2_valid (s2_valid),
    .s3       (s3),
    .s3_valid (s3_valid)
  );

  // Stage 4: compare; its register is the output register.
  rco_judge u_judge (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .s3        (s3),
    .s3_valid  (s3_valid),
    .hit       (hit),
    .out_valid (m_tvalid)
  );

  assign m_tdata = {{(rco_pkg::OUT_TDATA_BITS-1){1'b0}}, hit};

endmodule

`default_nettype wire

### rtl/core/rco_checker.sv
// rco_checker: port-level assertions for rect_circle_overlap_test, bound to
// the top level below. Depends on rco_pkg.
`default_nettype none

module rco_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               s_tvalid,
  input wire logic                               s_tready,
  input wire logic [rco_pkg::IN_TDATA_BITS-1:0]  s_tdata,
  input wire logic [rco_pkg::IN_TUSER_BITS-1:0]  s_tuser,
  input wire logic                               m_tvalid,
  input wire logic                               m_tready,
  input wire logic [rco_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

  // A result not taken stays and holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  // Input side opens exactly when the output register can move.
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready out of step with the output register");

  // Only the hit bit may be set.
  a_out_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[rco_pkg::OUT_TDATA_BITS-1:1] == '0)
    else $error("padding bits of m_tdata set");

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

endmodule

bind rect_circle_overlap_test rco_checker u_rco_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
